// File: rtl/core/rwpc_pkg.sv
// ----------------------------------------------------------------------------
// rwpc_pkg
// Shared codes, token type and color table of the pixel compositor.
// ----------------------------------------------------------------------------
package rwpc_pkg;

    // operation codes
    localparam logic [1:0] OP_WR_REGION   = 2'd0;
    localparam logic [1:0] OP_WR_OBSTACLE = 2'd1;
    localparam logic [1:0] OP_CLASSIFY    = 2'd2;

    // region kinds
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // pixel classes
    localparam logic [2:0] CLS_FLOOR_A  = 3'd0;
    localparam logic [2:0] CLS_FLOOR_B  = 3'd1;
    localparam logic [2:0] CLS_SPAWN    = 3'd2;
    localparam logic [2:0] CLS_MISSION  = 3'd3;
    localparam logic [2:0] CLS_NEST     = 3'd4;
    localparam logic [2:0] CLS_OBSTACLE = 3'd5;
    localparam logic [2:0] CLS_BORDER   = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_WORLD_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_WORLD_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BORDER       = 2'd2;

    localparam logic [15:0] WORLD_WIDTH_RST  = 16'd1024;
    localparam logic [15:0] WORLD_HEIGHT_RST = 16'd1024;
    localparam logic [7:0]  BORDER_RST       = 8'd10;

    // 8-pixel tiles: coordinate bit that flips the checkerboard
    localparam int TILE_BIT = 3;

    // one operation traveling down the cell chain
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic        ent_valid;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  kind;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [2:0]  cls;
        logic        done;   // region search finished
    } t_token;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    function automatic t_color class_color(logic [2:0] cls);
        t_color c;
        case (cls)
            CLS_FLOOR_A:  c = '{8'd31, 8'd37, 8'd32};
            CLS_FLOOR_B:  c = '{8'd35, 8'd41, 8'd35};
            CLS_SPAWN:    c = '{8'd35, 8'd70, 8'd45};
            CLS_MISSION:  c = '{8'd75, 8'd70, 8'd35};
            CLS_NEST:     c = '{8'd75, 8'd35, 8'd35};
            CLS_OBSTACLE: c = '{8'd70, 8'd65, 8'd55};
            CLS_BORDER:   c = '{8'd50, 8'd50, 8'd50};
            default:      c = '{8'd50, 8'd50, 8'd50};
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/rwpc_cell.sv
// ----------------------------------------------------------------------------
// rwpc_cell
// One table slot: holds a rectangle, tests the passing pixel against it.
// ----------------------------------------------------------------------------
module rwpc_cell #(
    parameter bit IS_OBSTACLE = 1'b0,
    parameter int CELL_INDEX  = 0,
    parameter int COORD_BITS  = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic            i_tok_valid,
    input  rwpc_pkg::t_token i_tok,
    output logic            o_tok_valid,
    output rwpc_pkg::t_token o_tok
);

    localparam logic [7:0] SLOT_ID = 8'(CELL_INDEX);
    localparam logic [1:0] WR_OP   = IS_OBSTACLE ? rwpc_pkg::OP_WR_OBSTACLE
                                                 : rwpc_pkg::OP_WR_REGION;

    logic [COORD_BITS-1:0] r_left, r_top, r_width, r_height;
    logic [1:0]            r_kind;
    logic                  r_ent_valid;
    logic                  r_tok_valid;
    rwpc_pkg::t_token      r_tok;
    rwpc_pkg::t_token      n_tok;

    logic [COORD_BITS-1:0] px, py;
    logic [COORD_BITS:0]   right, bottom;
    logic                  hit, wr, classify;

    assign px     = i_tok.pixel_x[COORD_BITS-1:0];
    assign py     = i_tok.pixel_y[COORD_BITS-1:0];
    // one extra bit so left+width never wraps
    assign right  = {1'b0, r_left} + {1'b0, r_width};
    assign bottom = {1'b0, r_top} + {1'b0, r_height};

    assign hit = r_ent_valid && (px >= r_left) && ({1'b0, px} < right)
              && (py >= r_top) && ({1'b0, py} < bottom);

    assign wr       = i_tok_valid && (i_tok.op == WR_OP) && (8'(i_tok.slot) == SLOT_ID);
    assign classify = i_tok_valid && (i_tok.op == rwpc_pkg::OP_CLASSIFY);

    always_comb begin
        n_tok = i_tok;
        if (classify && hit) begin
            if (IS_OBSTACLE) begin
                n_tok.cls = rwpc_pkg::CLS_OBSTACLE;
            end else if (!i_tok.done) begin
                // first containing region ends the search; unused kind keeps floor
                n_tok.done = 1'b1;
                if (r_kind != rwpc_pkg::KIND_UNUSED) begin
                    n_tok.cls = rwpc_pkg::CLS_SPAWN + {1'b0, r_kind};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= 1'b0;
            r_tok_valid <= 1'b0;
        end else if (i_advance) begin
            r_tok_valid <= i_tok_valid;
            if (wr) begin
                r_ent_valid <= i_tok.ent_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tok <= n_tok;
            if (wr) begin
                r_left   <= i_tok.left[COORD_BITS-1:0];
                r_top    <= i_tok.top[COORD_BITS-1:0];
                r_width  <= i_tok.width[COORD_BITS-1:0];
                r_height <= i_tok.height[COORD_BITS-1:0];
                r_kind   <= i_tok.kind;
            end
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

// File: rtl/core/rwpc_shade.sv
// ----------------------------------------------------------------------------
// rwpc_shade
// Border band override, palette lookup and the result register.
// ----------------------------------------------------------------------------
module rwpc_shade (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_tok_valid,
    input  rwpc_pkg::t_token i_tok,
    input  logic [15:0]      i_world_width,
    input  logic [15:0]      i_world_height,
    input  logic [7:0]       i_border,
    output logic             o_valid,
    output logic [2:0]       o_class,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);

    logic             r_valid;
    logic [2:0]       r_class;
    rwpc_pkg::t_color r_color;
    logic [2:0]       n_class;
    logic             in_band;

    always_comb begin
        in_band = (i_tok.pixel_x < {8'd0, i_border})
               || (i_tok.pixel_y < {8'd0, i_border})
               || (({1'b0, i_tok.pixel_x} + {9'd0, i_border}) >= {1'b0, i_world_width})
               || (({1'b0, i_tok.pixel_y} + {9'd0, i_border}) >= {1'b0, i_world_height});
        n_class = in_band ? rwpc_pkg::CLS_BORDER : i_tok.cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_tok_valid && (i_tok.op == rwpc_pkg::OP_CLASSIFY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_class <= n_class;
            r_color <= rwpc_pkg::class_color(n_class);
        end
    end

    assign o_valid = r_valid;
    assign o_class = r_class;
    assign o_red   = r_color.red;
    assign o_green = r_color.green;
    assign o_blue  = r_color.blue;

endmodule

// File: rtl/core/rect_window_pixel_compositor_top.sv
// ----------------------------------------------------------------------------
// rect_window_pixel_compositor_top
// Classifies and colors map pixels against region and obstacle rectangles.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | i_in_valid / o_in_stall    | operation, entry, rect, kind, pixel
//  out      | o_out_valid / i_out_stall  | pixel_class, color_red/green/blue
//  cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  One operation per cycle enters a row of cells while the row is not
//  stalled: MAX_REGIONS region cells, then MAX_OBSTACLES obstacle cells,
//  then the shading stage. Throughput is one transfer a cycle unless stalled.
//  Writes ride the same row as pixels, so every pixel sees the tables as
//  they stood when it was accepted.
//  Reset clears all slot valid bits at once and loads the config defaults.
//  A stalled result freezes the whole row; o_in_stall follows i_out_stall
//  only while a result is held.
//
module rect_window_pixel_compositor_top #(
    parameter int MAX_REGIONS   = 16,
    parameter int MAX_OBSTACLES = 16,
    parameter int COORD_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_entry_index,
    input  logic        i_entry_valid,
    input  logic [15:0] i_rect_left,
    input  logic [15:0] i_rect_top,
    input  logic [15:0] i_rect_width,
    input  logic [15:0] i_rect_height,
    input  logic [1:0]  i_region_kind,
    input  logic [15:0] i_pixel_x,
    input  logic [15:0] i_pixel_y,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_pixel_class,
    output logic [7:0]  o_color_red,
    output logic [7:0]  o_color_green,
    output logic [7:0]  o_color_blue
);

    localparam int N_CELLS = MAX_REGIONS + MAX_OBSTACLES;

    logic [15:0] r_world_width, r_world_height;
    logic [7:0]  r_border;

    logic             w_advance;
    logic             w_vld [0:N_CELLS];
    rwpc_pkg::t_token w_tok [0:N_CELLS];
    logic [15:0]      w_px, w_py;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_width  <= rwpc_pkg::WORLD_WIDTH_RST;
            r_world_height <= rwpc_pkg::WORLD_HEIGHT_RST;
            r_border       <= rwpc_pkg::BORDER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rwpc_pkg::CFG_WORLD_WIDTH:  r_world_width  <= i_cfg_data;
                rwpc_pkg::CFG_WORLD_HEIGHT: r_world_height <= i_cfg_data;
                rwpc_pkg::CFG_BORDER:       r_border       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // row moves unless a finished result is held while i_out_stall is high
    assign w_advance  = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_advance;

    // coordinates wrap to COORD_BITS
    assign w_px = 16'(i_pixel_x[COORD_BITS-1:0]);
    assign w_py = 16'(i_pixel_y[COORD_BITS-1:0]);

    always_comb begin
        w_vld[0]           = i_in_valid;
        w_tok[0].op        = i_operation;
        w_tok[0].slot      = i_entry_index;
        w_tok[0].ent_valid = i_entry_valid;
        w_tok[0].left      = i_rect_left;
        w_tok[0].top       = i_rect_top;
        w_tok[0].width     = i_rect_width;
        w_tok[0].height    = i_rect_height;
        w_tok[0].kind      = i_region_kind;
        w_tok[0].pixel_x   = w_px;
        w_tok[0].pixel_y   = w_py;
        // checkerboard floor is the base layer
        w_tok[0].cls       = (w_px[rwpc_pkg::TILE_BIT] ^ w_py[rwpc_pkg::TILE_BIT])
                           ? rwpc_pkg::CLS_FLOOR_B : rwpc_pkg::CLS_FLOOR_A;
        w_tok[0].done      = 1'b0;
    end

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_region
        rwpc_cell #(
            .IS_OBSTACLE (1'b0),
            .CELL_INDEX  (g),
            .COORD_BITS  (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (w_advance),
            .i_tok_valid (w_vld[g]),
            .i_tok       (w_tok[g]),
            .o_tok_valid (w_vld[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

    for (genvar g = 0; g < MAX_OBSTACLES; g++) begin : g_obstacle
        rwpc_cell #(
            .IS_OBSTACLE (1'b1),
            .CELL_INDEX  (g),
            .COORD_BITS  (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (w_advance),
            .i_tok_valid (w_vld[MAX_REGIONS+g]),
            .i_tok       (w_tok[MAX_REGIONS+g]),
            .o_tok_valid (w_vld[MAX_REGIONS+g+1]),
            .o_tok       (w_tok[MAX_REGIONS+g+1])
        );
    end

    rwpc_shade u_shade (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_tok_valid    (w_vld[N_CELLS]),
        .i_tok          (w_tok[N_CELLS]),
        .i_world_width  (r_world_width),
        .i_world_height (r_world_height),
        .i_border       (r_border),
        .o_valid        (o_out_valid),
        .o_class        (o_pixel_class),
        .o_red          (o_color_red),
        .o_green        (o_color_green),
        .o_blue         (o_color_blue)
    );

    // ---- assertions ----
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pixel_class != 3'd7))
        else $error("pixel class out of range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result held");

    a_color_matches_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({o_color_red, o_color_green, o_color_blue}
                         == rwpc_pkg::class_color(o_pixel_class)))
        else $error("color does not match pixel class");

endmodule
